// ===== rtl/core/arwc_pkg.sv =====
// ----------------------------------------------------------------------------
// arwc_pkg
// Shared widths, reset values and verdict codes of the anti-replay check.
// ----------------------------------------------------------------------------
package arwc_pkg;

    // sequence number width and window size (window must be a power of two)
    localparam int SEQ_BITS    = 48;
    localparam int WINDOW_BITS = 64;
    localparam int SLOT_BITS   = $clog2(WINDOW_BITS);

    // reset value of the window top, so the first window covers 0 .. window - 1
    localparam logic [SEQ_BITS-1:0] TOP_RESET = SEQ_BITS'(WINDOW_BITS - 1);
    localparam logic [SEQ_BITS-1:0] WINDOW_SPAN = SEQ_BITS'(WINDOW_BITS);

    typedef logic [SEQ_BITS-1:0]    seq_t;
    typedef logic [WINDOW_BITS-1:0] bitmap_t;
    typedef logic [SLOT_BITS-1:0]   slot_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT   = 2'd0,
        VERDICT_TOO_OLD  = 2'd1,
        VERDICT_REPLAYED = 2'd2
    } verdict_t;

endpackage

// ===== rtl/core/anti_replay_window_check_core.sv =====
// ----------------------------------------------------------------------------
// anti_replay_window_check_core
// Sliding-window replay check of 48-bit record sequence numbers.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one sequence number per transaction (valid/ready)
//   m_ channel: one verdict per transaction, 0 accept, 1 too old, 2 replayed
//   path: a number accepted into the input register moves, when the result
//     register is free, through the check into the result register, which
//     raises m_valid
//   throughput: one transaction per cycle while m_ready keeps the result register
//     draining; the window update for an item finishes in the same cycle it is checked, so the next item sees it
//   stalls: the result register and the input register each hold one item;
//     with m_ready low both fill and s_ready drops, nothing is lost
//   reset: aresetn low clears both registers, sets the window top to 63
//     and clears the seen bitmap; no clearing pass is needed
//   the check/update is combinational: 48-bit compares plus a 64-slot
//   circular range mask, which sets the critical path
// ----------------------------------------------------------------------------
module anti_replay_window_check_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [47:0] s_seq_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict
);

    logic               in_valid;
    arwc_pkg::seq_t     in_seq;
    logic               out_free;
    logic               advance;
    arwc_pkg::verdict_t verdict;

    // the held item moves to the result register when that one is free
    assign advance = in_valid && out_free;

    arwc_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_seq_number (arwc_pkg::seq_t'(s_seq_number)),
        .advance      (advance),
        .in_valid     (in_valid),
        .in_seq       (in_seq)
    );

    // window state is updated only for the item that moves on
    arwc_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .seq     (in_seq),
        .verdict (verdict)
    );

    arwc_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .verdict   (verdict),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_verdict (m_verdict)
    );

endmodule

// ===== rtl/core/arwc_in_stage.sv =====
// ----------------------------------------------------------------------------
// arwc_in_stage
// Input register: holds one sequence number until the check stage takes it.
// ----------------------------------------------------------------------------
module arwc_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  arwc_pkg::seq_t s_seq_number,
    input  logic          advance,
    output logic          in_valid,
    output arwc_pkg::seq_t in_seq
);

    logic           valid_reg;
    logic           valid_next;
    arwc_pkg::seq_t seq_reg;

    // free when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            seq_reg <= s_seq_number;
        end
    end

    assign in_valid = valid_reg;
    assign in_seq   = seq_reg;

endmodule

// ===== rtl/core/arwc_window.sv =====
// ----------------------------------------------------------------------------
// arwc_window
// Window state (top and circular bitmap) with the combinational check/update.
// ----------------------------------------------------------------------------
module arwc_window (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  arwc_pkg::seq_t     seq,
    output arwc_pkg::verdict_t verdict
);

    arwc_pkg::seq_t    top_reg;
    arwc_pkg::seq_t    top_next;
    arwc_pkg::bitmap_t bitmap_reg;
    arwc_pkg::bitmap_t bitmap_next;

    arwc_pkg::seq_t    floor_seq;
    arwc_pkg::seq_t    gap;
    arwc_pkg::slot_t   pos;
    arwc_pkg::slot_t   top_slot;
    arwc_pkg::slot_t   gap_lo;
    arwc_pkg::bitmap_t pos_mask;
    arwc_pkg::bitmap_t clear_mask;
    logic              too_old;
    logic              in_window;
    logic              big_jump;

    // top never drops below window - 1, so the floor never wraps
    assign floor_seq = top_reg - arwc_pkg::TOP_RESET;
    assign too_old   = seq < floor_seq;
    assign in_window = seq <= top_reg;
    assign gap       = seq - top_reg;
    assign big_jump  = gap >= arwc_pkg::WINDOW_SPAN;
    assign pos       = seq[arwc_pkg::SLOT_BITS-1:0];
    assign top_slot  = top_reg[arwc_pkg::SLOT_BITS-1:0];
    assign gap_lo    = gap[arwc_pkg::SLOT_BITS-1:0];

    // slots strictly between old top and new top, by circular distance
    always_comb begin
        arwc_pkg::slot_t slot_dist;
        clear_mask = '0;
        pos_mask   = '0;
        for (int i = 0; i < arwc_pkg::WINDOW_BITS; i++) begin
            slot_dist     = arwc_pkg::slot_t'(i) - top_slot;
            clear_mask[i] = big_jump || ((slot_dist != '0) && (slot_dist < gap_lo));
            pos_mask[i]   = (pos == arwc_pkg::slot_t'(i));
        end
    end

    always_comb begin
        top_next    = top_reg;
        bitmap_next = bitmap_reg;
        if (too_old) begin
            verdict = arwc_pkg::VERDICT_TOO_OLD;
        end else if (in_window) begin
            verdict     = bitmap_reg[pos] ? arwc_pkg::VERDICT_REPLAYED
                                          : arwc_pkg::VERDICT_ACCEPT;
            bitmap_next = bitmap_reg | pos_mask;
        end else begin
            verdict     = arwc_pkg::VERDICT_ACCEPT;
            bitmap_next = (bitmap_reg & ~clear_mask) | pos_mask;
            top_next    = seq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg    <= arwc_pkg::TOP_RESET;
            bitmap_reg <= '0;
        end else if (advance) begin
            top_reg    <= top_next;
            bitmap_reg <= bitmap_next;
        end
    end

endmodule

// ===== rtl/core/arwc_out_stage.sv =====
// ----------------------------------------------------------------------------
// arwc_out_stage
// Result register: holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module arwc_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  arwc_pkg::verdict_t verdict,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_verdict
);

    logic               valid_reg;
    logic               valid_next;
    arwc_pkg::verdict_t verdict_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            verdict_reg <= verdict;
        end
    end

    assign m_valid   = valid_reg;
    assign m_verdict = verdict_reg;

endmodule

// ===== tb/sv/arwc_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_verdict_checker
// Watches both channels of the anti-replay check, predicts the verdict of
// every accepted sequence number and compares it with the returned one.
// ----------------------------------------------------------------------------
module arwc_verdict_checker
    import arwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [47:0] s_seq_number,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_verdict,
    output int          fail_count,
    output int          pending_count
);

    localparam int REPORT_LIMIT = 10;

    seq_t     window_top     = TOP_RESET;
    bitmap_t  seen_map       = '0;
    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;

    // window is a power of two, so the slot of a number is its low bits
    function automatic verdict_t judge_seq(input seq_t seq);
        seq_t     low_edge;
        seq_t     jump;
        seq_t     d;
        verdict_t v;
        low_edge = window_top - seq_t'(WINDOW_BITS - 1);
        v = VERDICT_ACCEPT;
        if (seq < low_edge) begin
            v = VERDICT_TOO_OLD;
        end else if (seq <= window_top) begin
            if (seen_map[slot_t'(seq)]) begin
                v = VERDICT_REPLAYED;
            end
            seen_map[slot_t'(seq)] = 1'b1;
        end else begin
            jump = seq - window_top;
            if (jump >= WINDOW_SPAN) begin
                seen_map = '0;
            end else begin
                for (d = 1; d < jump; d++) begin
                    seen_map[slot_t'(window_top + d)] = 1'b0;
                end
            end
            seen_map[slot_t'(seq)] = 1'b1;
            window_top = seq;
        end
        return v;
    endfunction

    function automatic void note_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("[%0t] verdict mismatch: %s", $realtime, what);
        end
        mismatch_count = mismatch_count + 1;
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            window_top = TOP_RESET;
            seen_map   = '0;
            pending_verdicts.delete();
        end else begin
            if (s_valid && s_ready) begin
                pending_verdicts.push_back(judge_seq(s_seq_number));
            end
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    note_mismatch($sformatf("unexpected verdict %0d", m_verdict));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_verdict !== want) begin
                        note_mismatch($sformatf("expected %0d (%s), got %0d",
                                                want, want.name(), m_verdict));
                    end
                end
            end
        end
        fail_count    <= mismatch_count;
        pending_count <= pending_verdicts.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the anti-replay window check. Drives sequence
// numbers in random bursts aimed around the moving window, stalls the
// verdict channel on its own pattern, and leaves prediction to the checker.
// ----------------------------------------------------------------------------
module tb;
    import arwc_pkg::*;

    // roughly the requested number of random transactions
    localparam int RANDOM_ITEMS = 1400;
    // generous cap: far above the slowest legal run with all stalls
    localparam int CYCLE_LIMIT  = 400000;
    localparam seq_t SEQ_MAX    = '1;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_TOGGLE,
        RX_HOLD
    } rx_mode_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [47:0] s_seq_number = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [1:0]  m_verdict;

    int          fail_count;
    int          pending_count;
    int          cycle_count  = 0;

    // highest number offered so far, only used to aim the stimulus
    seq_t        stim_top     = TOP_RESET;

    // opening sequence from reset (window 0..63): in-window accept and
    // replay, number equal to the top, jump of one, just below the window,
    // jump of two clearing the skipped slot, large jump clearing all,
    // lower window edge, jump of window minus one, and wide bit patterns
    seq_t opening_seqs[$] = '{
        48'd0, 48'd0, 48'd63, 48'd63, 48'd1, 48'd64, 48'd0, 48'd1,
        48'd66, 48'd65, 48'd200, 48'd137, 48'd136, 48'd200, 48'd263,
        48'd200, 48'd201, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
        48'h5555_5555_5555
    };

    // closing sequence at the top of the number range, sent last since
    // the window can never move again once it reaches the maximum
    seq_t closing_seqs[$] = '{
        SEQ_MAX - 48'd1, SEQ_MAX, SEQ_MAX, SEQ_MAX - 48'd63,
        SEQ_MAX - 48'd64, 48'd0
    };

    int          sent;
    int          burst_len;
    int          gap_len;
    int          k;

    anti_replay_window_check_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_seq_number (s_seq_number),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_verdict    (m_verdict)
    );

    arwc_verdict_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_seq_number  (s_seq_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // add a step to a base number, saturating at the top of the range
    function automatic seq_t advance_by(input seq_t base, input seq_t step);
        logic [SEQ_BITS:0] wide;
        wide = {1'b0, base} + {1'b0, step};
        return wide[SEQ_BITS] ? SEQ_MAX : wide[SEQ_BITS-1:0];
    endfunction

    // mostly numbers in and just around the window, some forward moves of
    // every size, a few far below the window and rare huge jumps
    function automatic seq_t pick_seq();
        int unsigned roll;
        seq_t        low_edge;
        logic [63:0] r64;
        roll     = $urandom_range(0, 99);
        low_edge = stim_top - seq_t'(WINDOW_BITS - 1);
        r64      = {$urandom, $urandom};
        if (roll < 28) begin
            return stim_top - seq_t'($urandom_range(0, WINDOW_BITS - 1));
        end else if (roll < 34) begin
            // right at the lower window edge or one below it
            return (low_edge == 0) ? low_edge
                                   : low_edge - seq_t'($urandom_range(0, 1));
        end else if (roll < 58) begin
            return advance_by(stim_top, seq_t'($urandom_range(1, 4)));
        end else if (roll < 68) begin
            return advance_by(stim_top, seq_t'($urandom_range(5, 70)));
        end else if (roll < 73) begin
            // jumps straddling the window size
            return advance_by(stim_top,
                              seq_t'($urandom_range(WINDOW_BITS - 2, WINDOW_BITS + 2)));
        end else if (roll < 77) begin
            return advance_by(stim_top, seq_t'($urandom_range(71, 300)));
        end else if (roll < 79) begin
            return advance_by(stim_top,
                              (roll == 77) ? seq_t'(r64[31:0]) : seq_t'(r64[43:0]));
        end else if (roll < 89) begin
            return (low_edge == 0) ? stim_top : seq_t'(r64 % low_edge);
        end else begin
            // recent numbers, mostly replays
            return stim_top - seq_t'($urandom_range(0, 3));
        end
    endfunction

    // offer one number and hold it until the block takes it
    task automatic offer_seq(input seq_t seq);
        s_valid      <= 1'b1;
        s_seq_number <= seq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (seq > stim_top) begin
            stim_top = seq;
        end
    endtask

    // receiver: a short random start, one long hold so the block backs up
    // into its input, then random patterns with an occasional long hold
    initial begin
        rx_mode_t mode;
        int       len;
        int       i;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        for (i = 0; i < 30; i++) begin
            m_ready <= ($urandom_range(0, 1) == 1);
            @(posedge aclk);
        end
        m_ready <= 1'b0;
        repeat (250) @(posedge aclk);
        forever begin
            mode = rx_mode_t'($urandom_range(0, 24) == 0 ? RX_HOLD
                                                         : $urandom_range(0, 3));
            len  = (mode == RX_HOLD) ? $urandom_range(100, 300)
                                     : $urandom_range(10, 80);
            for (i = 0; i < len; i++) begin
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    RX_TOGGLE: m_ready <= i[0];
                    default:   m_ready <= 1'b0;
                endcase
                @(posedge aclk);
            end
        end
    end

    // sender and verdict
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_seqs[j]) begin
            offer_seq(opening_seqs[j]);
        end

        // random part in bursts, sometimes back to back with no gap
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(1, 40);
            for (k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
                offer_seq(pick_seq());
                sent++;
            end
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_len != 0) begin
                s_valid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end

        foreach (closing_seqs[j]) begin
            offer_seq(closing_seqs[j]);
        end
        s_valid <= 1'b0;

        // drain every expected verdict, then wait a little longer for strays
        do @(posedge aclk); while (pending_count != 0);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
